[design/gwpol_pkg.sv]
// Shared widths, codes and request/entry types for the occupied-cell list block.
package gwpol_pkg;

  localparam int COORD_W   = 6;
  localparam int KIND_W    = 2;
  localparam int UV_W      = 10;
  localparam int IDX_W     = 12;
  localparam int TOTAL_W   = 13;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_GRID_WIDTH  = 64;
  localparam int DEF_GRID_HEIGHT = 64;
  localparam int DEF_LIST_DEPTH  = 4096;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GRASS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAND  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WATER = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRASS_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRASS_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAND_U  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAND_V  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_U = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WATER_V = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [UV_W-1:0]    u;
    logic [UV_W-1:0]    v;
  } entry_t;

  typedef struct packed {
    logic               cmd;
    logic               oor;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [KIND_W-1:0]  kind;
    logic [UV_W-1:0]    u;
    logic [UV_W-1:0]    v;
    logic [IDX_W-1:0]   idx;
  } req_t;

endpackage

[design/grid_with_packed_occupied_list.sv]
// Top level: grid of typed cells with a packed list of occupied cells.
//
// Usage:
//   Requests enter on start/in_* and are taken when start is high and busy is
//   low. A set request (command 0) changes one cell's kind and keeps the packed
//   list in step: append on first occupation, swap-remove on clearing, u/v
//   rewrite on a kind change. A read request (command 1) returns list entry
//   in_entry_index. Every request yields exactly one result, shown for one
//   cycle with out_valid high; the receiver cannot stall it.
//   Atlas u/v registers are written on cfg_valid/cfg_index/cfg_data; the user
//   must do so only while the block is idle (unchecked); cfg_ready is always high.
// Flow:
//   A taken request waits in the queue, is popped into the back end as the
//   cell memories are read, is evaluated, and has its result registered; a
//   removal that moves the tail entry also passes a move state. The back end
//   takes the next request only when idle. A two-entry queue lets requests be
//   taken while the back end works; busy rises when it is full.
// Reset:
//   rst_n clears the count and registers, then the cell kind store is swept to
//   empty one cell a cycle over all GRID_WIDTH*GRID_HEIGHT cells (4096 by
//   default), with busy held high.
module grid_with_packed_occupied_list
  import gwpol_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
  parameter int LIST_DEPTH  = DEF_LIST_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [COORD_W-1:0]   in_cell_x,
  input  logic [COORD_W-1:0]   in_cell_y,
  input  logic [KIND_W-1:0]    in_new_kind,
  input  logic [IDX_W-1:0]     in_entry_index,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [TOTAL_W-1:0]   out_occupied_total,
  output logic [COORD_W-1:0]   out_entry_x,
  output logic [COORD_W-1:0]   out_entry_y,
  output logic [UV_W-1:0]      out_entry_u,
  output logic [UV_W-1:0]      out_entry_v,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [UV_W-1:0]      cfg_data
);

  logic push, pop, q_full, q_empty, clearing;
  req_t push_req, pop_req;

  assign busy      = q_full || clearing;
  assign cfg_ready = 1'b1;

  gwpol_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .hold           (busy),
    .in_command     (in_command),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_new_kind    (in_new_kind),
    .in_entry_index (in_entry_index),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .push_req       (push_req)
  );

  gwpol_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .full     (q_full),
    .empty    (q_empty)
  );

  gwpol_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .LIST_DEPTH  (LIST_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_req              (pop_req),
    .q_pop              (pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_occupied_total (out_occupied_total),
    .out_entry_x        (out_entry_x),
    .out_entry_y        (out_entry_y),
    .out_entry_u        (out_entry_u),
    .out_entry_v        (out_entry_v)
  );

endmodule

[design/gwpol_front.sv]
// Front end: accepts requests, range-checks them and resolves atlas u/v.
module gwpol_front
  import gwpol_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 hold,
  input  logic                 in_command,
  input  logic [COORD_W-1:0]   in_cell_x,
  input  logic [COORD_W-1:0]   in_cell_y,
  input  logic [KIND_W-1:0]    in_new_kind,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [UV_W-1:0]      cfg_data,
  output logic                 push,
  output req_t                 push_req
);

  logic [UV_W-1:0] grass_u_r, grass_v_r, sand_u_r, sand_v_r, water_u_r, water_v_r;
  logic            oor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grass_u_r <= '0;
      grass_v_r <= '0;
      sand_u_r  <= '0;
      sand_v_r  <= '0;
      water_u_r <= '0;
      water_v_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRASS_U: grass_u_r <= cfg_data;
        REG_GRASS_V: grass_v_r <= cfg_data;
        REG_SAND_U:  sand_u_r  <= cfg_data;
        REG_SAND_V:  sand_v_r  <= cfg_data;
        REG_WATER_U: water_u_r <= cfg_data;
        REG_WATER_V: water_v_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign oor = (in_command == CMD_SET) &&
               ((32'(in_cell_x) >= 32'(GRID_WIDTH)) || (32'(in_cell_y) >= 32'(GRID_HEIGHT)));

  assign push = start && !hold;

  always_comb begin
    push_req      = '0;
    push_req.cmd  = in_command;
    push_req.oor  = oor;
    push_req.x    = in_cell_x;
    push_req.y    = in_cell_y;
    push_req.kind = in_new_kind;
    push_req.idx  = in_entry_index;
    case (in_new_kind)
      KIND_SAND: begin
        push_req.u = sand_u_r;
        push_req.v = sand_v_r;
      end
      KIND_WATER: begin
        push_req.u = water_u_r;
        push_req.v = water_v_r;
      end
      default: begin
        push_req.u = grass_u_r;
        push_req.v = grass_v_r;
      end
    endcase
  end

endmodule

[design/gwpol_queue.sv]
// Short request queue between the front end and the back end.
module gwpol_queue
  import gwpol_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t pop_req,
  output logic full,
  output logic empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;

  assign full    = (fill_r == CW'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_req = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

[design/gwpol_back.sv]
// Back end: owns the cell and list memories and executes one request at a time.
module gwpol_back
  import gwpol_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
  parameter int LIST_DEPTH  = DEF_LIST_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  req_t                q_req,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [TOTAL_W-1:0]  out_occupied_total,
  output logic [COORD_W-1:0]  out_entry_x,
  output logic [COORD_W-1:0]  out_entry_y,
  output logic [UV_W-1:0]     out_entry_u,
  output logic [UV_W-1:0]     out_entry_v
);

  localparam int CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_TOTAL);
  localparam int LIST_AW    = $clog2(LIST_DEPTH);
  localparam int CNT_W      = LIST_AW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    cell_addr = CELL_AW'(y) * CELL_AW'(GRID_WIDTH) + CELL_AW'(x);
  endfunction

  logic [KIND_W-1:0]  kind_mem [CELL_TOTAL];
  logic [LIST_AW-1:0] slot_mem [CELL_TOTAL];
  entry_t             list_mem [LIST_DEPTH];

  logic [1:0]         state_r, state_nxt;
  req_t               req_r;
  logic [CELL_AW-1:0] cell_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LIST_AW-1:0] move_slot_r, move_slot_nxt;
  logic               clr_active_r;
  logic [CELL_AW-1:0] clr_addr_r;

  logic [KIND_W-1:0]  kind_q;
  logic [LIST_AW-1:0] slot_q;
  entry_t             list_q;

  logic [CELL_AW-1:0] rd_cell;
  logic [LIST_AW-1:0] list_raddr;

  logic               kind_we;
  logic [CELL_AW-1:0] kind_waddr;
  logic [KIND_W-1:0]  kind_wdata;
  logic               slot_we;
  logic [CELL_AW-1:0] slot_waddr;
  logic [LIST_AW-1:0] slot_wdata;
  logic               list_we;
  logic [LIST_AW-1:0] list_waddr;
  entry_t             list_wdata;

  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TOTAL_W-1:0] out_total_r;
  entry_t             out_entry_r, out_entry_nxt;

  logic [CNT_W-1:0]   last_idx;
  logic               read_hit;
  entry_t             fresh_entry;

  assign clearing = clr_active_r;
  assign q_pop    = (state_r == S_IDLE) && !q_empty && !clr_active_r;
  assign rd_cell  = cell_addr(q_req.x, q_req.y);
  assign last_idx = count_r - 1'b1;
  assign read_hit = (32'(req_r.idx) < 32'(count_r));

  always_comb begin
    fresh_entry   = '0;
    fresh_entry.x = req_r.x;
    fresh_entry.y = req_r.y;
    fresh_entry.u = req_r.u;
    fresh_entry.v = req_r.v;
  end

  // memories: one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[kind_waddr] <= kind_wdata;
    end
    kind_q <= kind_mem[rd_cell];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[rd_cell];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_q <= list_mem[list_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    move_slot_nxt  = move_slot_r;
    kind_we        = 1'b0;
    kind_waddr     = cell_r;
    kind_wdata     = req_r.kind;
    slot_we        = 1'b0;
    slot_waddr     = cell_r;
    slot_wdata     = count_r[LIST_AW-1:0];
    list_we        = 1'b0;
    list_waddr     = count_r[LIST_AW-1:0];
    list_wdata     = fresh_entry;
    list_raddr     = LIST_AW'(q_req.idx);
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_entry_nxt  = '0;

    if (clr_active_r) begin
      kind_we    = 1'b1;
      kind_waddr = clr_addr_r;
      kind_wdata = KIND_EMPTY;
    end

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (req_r.cmd == CMD_READ) begin
          if (read_hit) begin
            out_entry_nxt = list_q;
          end else begin
            out_status_nxt = ST_INDEX;
          end
        end else if (req_r.oor) begin
          out_status_nxt = ST_RANGE;
        end else if (kind_q == KIND_EMPTY) begin
          if (req_r.kind != KIND_EMPTY) begin
            if (count_r == CNT_W'(LIST_DEPTH)) begin
              out_status_nxt = ST_INDEX;
            end else begin
              // append at the tail
              list_we   = 1'b1;
              slot_we   = 1'b1;
              kind_we   = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
        end else if (req_r.kind != KIND_EMPTY) begin
          // change kind: refresh u/v in place
          kind_we = 1'b1;
          if ({1'b0, slot_q} < count_r) begin
            list_we    = 1'b1;
            list_waddr = slot_q;
          end
        end else begin
          kind_we = 1'b1;
          if (count_r != '0) begin
            count_nxt = last_idx;
            if ({1'b0, slot_q} < last_idx) begin
              // fetch the tail entry and fill the hole next cycle
              list_raddr    = last_idx[LIST_AW-1:0];
              move_slot_nxt = slot_q;
              out_valid_nxt = 1'b0;
              state_nxt     = S_MOVE;
            end
          end
        end
      end
      S_MOVE: begin
        state_nxt     = S_IDLE;
        list_we       = 1'b1;
        list_waddr    = move_slot_r;
        list_wdata    = list_q;
        slot_we       = 1'b1;
        slot_waddr    = cell_addr(list_q.x, list_q.y);
        slot_wdata    = move_slot_r;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CELL_AW'(CELL_TOTAL - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r  <= q_req;
      cell_r <= rd_cell;
    end
    move_slot_r  <= move_slot_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= TOTAL_W'(count_nxt);
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_occupied_total = out_total_r;
  assign out_entry_x        = out_entry_r.x;
  assign out_entry_y        = out_entry_r.y;
  assign out_entry_u        = out_entry_r.u;
  assign out_entry_v        = out_entry_r.v;

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (state_r == S_IDLE) && !out_valid_r)
    else $error("result or work during clearing pass");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1) || (count_r + 1'b1 == $past(count_r)))
    else $error("entry count moved by more than one");

  a_move_follows_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> ($past(state_r) == S_EVAL) && !out_valid_r)
    else $error("swap move not entered from evaluation");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_EVAL) || ($past(state_r) == S_MOVE))
    else $error("result without an executed request");

endmodule
